[hdl/sit_pkg.sv]
// Package for the sorted insert table: sizes, operation and status codes,
// and the result record passed from the sequencer to the output buffer.
// No dependencies.
package sit_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int RANK_W   = 4;
    localparam int CMP_W    = (CNT_W > RANK_W) ? CNT_W : RANK_W;
    localparam int DATA_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int FILL_W   = 5;
    localparam int STAT_W   = 2;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    // One result item
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] stored_value;
        logic [FILL_W-1:0]        fill_count;
    } sit_result_t;

endpackage

[hdl/sit_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module sit_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/sit_ctrl.sv]
// Sequencer for the sorted insert table: accepts items, walks the entry RAM
// from the top down to shift entries and place a new value, serves reads.
// Depends on sit_pkg.
module sit_ctrl
    import sit_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic signed [DATA_W-1:0] value,
    input  logic [RANK_W-1:0]        rank,
    input  logic                     res_free,
    output logic                     res_valid,
    output sit_result_t              res,
    output logic                     ram_we,
    output logic [IDX_W-1:0]         ram_waddr,
    output logic [DATA_W-1:0]        ram_wdata,
    output logic                     ram_re,
    output logic [IDX_W-1:0]         ram_raddr,
    input  logic [DATA_W-1:0]        ram_rdata
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_PLACE  = 2'd2;
    localparam logic [1:0] S_RDWAIT = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [RANK_W-1:0]        slot_reg, slot_next;

    logic [IDX_W-1:0] idx_up;
    logic [IDX_W-1:0] idx_dn;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] count_dec;
    logic             accept;

    assign in_ready  = (state_reg == S_IDLE) && res_free;
    assign accept    = in_valid && in_ready;
    assign idx_up    = idx_reg + 1'b1;
    assign idx_dn    = idx_reg - 1'b1;
    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Item payload and scan index
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        slot_reg <= slot_next;
    end

    // Sequencer: accepts inserts and reads; top-down scan moves entries >= value up by one slot
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        val_next   = val_reg;
        slot_next  = slot_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = val_reg;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg;
        res_valid  = 1'b0;
        res        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_INSERT)
                    begin
                        val_next = value;
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_valid      = 1'b1;
                            res.status     = STAT_FULL;
                            res.fill_count = FILL_W'(count_reg);
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = IDX_W'(count_dec);
                            idx_next   = IDX_W'(count_dec);
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        slot_next = rank;
                        if (CMP_W'(rank) >= CMP_W'(count_reg))
                        begin
                            res_valid      = 1'b1;
                            res.status     = STAT_RANGE;
                            res.slot       = SLOT_W'(rank);
                            res.fill_count = FILL_W'(count_reg);
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = IDX_W'(rank);
                            state_next = S_RDWAIT;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_up;
                if ($signed(ram_rdata) >= val_reg)
                begin
                    // entry moves up; keep walking down
                    ram_wdata = ram_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_dn;
                        idx_next  = idx_dn;
                    end
                end
                else
                begin
                    // first smaller entry found: value lands just above it
                    ram_wdata      = val_reg;
                    count_next     = count_inc;
                    res_valid      = 1'b1;
                    res.status     = STAT_OK;
                    res.slot       = SLOT_W'(idx_up);
                    res.fill_count = FILL_W'(count_inc);
                    state_next     = S_IDLE;
                end
            end

            S_PLACE:
            begin
                ram_we         = 1'b1;
                ram_waddr      = '0;
                ram_wdata      = val_reg;
                count_next     = count_inc;
                res_valid      = 1'b1;
                res.status     = STAT_OK;
                res.fill_count = FILL_W'(count_inc);
                state_next     = S_IDLE;
            end

            S_RDWAIT:
            begin
                res_valid        = 1'b1;
                res.status       = STAT_OK;
                res.slot         = SLOT_W'(slot_reg);
                res.stored_value = $signed(ram_rdata);
                res.fill_count   = FILL_W'(count_reg);
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Scan index stays inside the filled part of the table
    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ({1'b0, idx_reg} < (IDX_W+1)'(count_reg)))
        else $error("scan index outside filled range");

    // A finished insert grows the count by exactly one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == STAT_OK && state_reg != S_RDWAIT)
        |=> (count_reg == $past(count_inc)))
        else $error("insert did not bump count by one");

endmodule

[hdl/sit_out.sv]
// Result buffer: one pending slot behind the output register so a result
// can be finished while the previous one waits for the consumer.
// Depends on sit_pkg.
module sit_out
    import sit_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     res_valid,
    input  sit_result_t              res,
    output logic                     res_free,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STAT_W-1:0]        status,
    output logic [SLOT_W-1:0]        slot,
    output logic signed [DATA_W-1:0] stored_value,
    output logic [FILL_W-1:0]        fill_count
);

    logic        pend_reg;
    sit_result_t pend_data_reg;
    logic        out_valid_reg;
    sit_result_t out_data_reg;
    logic        take_out;

    assign take_out = !out_valid_reg || out_ready;
    assign res_free = !pend_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_out)
            begin
                out_valid_reg <= pend_reg || res_valid;
                pend_reg      <= 1'b0;
            end
            else if (res_valid)
            begin
                pend_reg <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (take_out)
        begin
            out_data_reg <= pend_reg ? pend_data_reg : res;
        end
        else if (res_valid)
        begin
            pend_data_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_data_reg.status;
    assign slot         = out_data_reg.slot;
    assign stored_value = out_data_reg.stored_value;
    assign fill_count   = out_data_reg.fill_count;

    // A new result never lands on an occupied pending slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !pend_reg)
        else $error("result overwrote pending entry");

endmodule

[hdl/sorted_insert_table.sv]
// Top level of the sorted insert table: sequencer, entry RAM, result buffer.
// Depends on sit_pkg, sit_ram, sit_ctrl, sit_out.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  input    | in_valid / in_ready  | operation, value, rank
//  output   | out_valid / out_ready| status, slot, stored_value, fill_count
//
// An insert reads and writes back each entry moved, since the single RAM read
// port walks the table top down; a read waits for the registered RAM read.
// A full-table insert or an out-of-range read is answered directly from idle.
// Reset clears the entry count, the sequencer state and the result valid flags;
// the RAM needs no clearing. One finished result can wait in a pending slot
// behind the output register; input stalls while that slot is occupied or an item is in progress.
module sorted_insert_table
    import sit_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic signed [DATA_W-1:0] value,
    input  logic [RANK_W-1:0]        rank,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STAT_W-1:0]        status,
    output logic [SLOT_W-1:0]        slot,
    output logic signed [DATA_W-1:0] stored_value,
    output logic [FILL_W-1:0]        fill_count
);

    logic              res_free;
    logic              res_valid;
    sit_result_t       res;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    sit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .value     (value),
        .rank      (rank),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    sit_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sit_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .res_free     (res_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .slot         (slot),
        .stored_value (stored_value),
        .fill_count   (fill_count)
    );

endmodule
